/* sv/hpr_pkg.sv */
package hpr_pkg;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_START  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		CFG_TARGET    = 3'd0,
		CFG_STEP      = 3'd1,
		CFG_GAIN_NOW  = 3'd2,
		CFG_GAIN_PREV = 3'd3,
		CFG_THRESHOLD = 3'd4
	} cfg_idx_t;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 31;

	localparam logic [30:0]        TargetRst    = 31'd0;
	localparam logic [30:0]        StepRst      = 31'd65536;
	localparam logic signed [15:0] GainNowRst   = 16'sd4643;
	localparam logic signed [15:0] GainPrevRst  = -16'sd4637;
	localparam logic [30:0]        ThresholdRst = 31'd6554;

	// stage 2 word: error of this sample and of the one before
	typedef struct packed {
		op_t                op;
		logic signed [31:0] err;
		logic signed [31:0] prev_err;
	} err_word_t;

	// stage 3 word: rounded action increment
	typedef struct packed {
		op_t                op;
		logic signed [33:0] delta;
	} delta_word_t;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -35'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

/* sv/hpr_in_if.sv */
interface hpr_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [31:0] angle_increment;

	modport source (output valid, output operation, output angle_increment, input ready);
	modport sink (input valid, input operation, input angle_increment, output ready);
endinterface

/* sv/hpr_out_if.sv */
interface hpr_out_if;
	logic        valid;
	logic        ready;
	logic [30:0] drive;
	logic        stop_motors;

	modport source (output valid, output drive, output stop_motors, input ready);
	modport sink (input valid, input drive, input stop_motors, output ready);
endinterface

/* sv/heading_pi_with_ramp.sv */
// Heading PI controller, velocity form, Q16.16 angles and Q1.15 gains.
// Channels: sample (sink) takes one word per control tick, operation 0 for a
// measured angle increment, 1 to start a new heading; result (source) gives
// drive and stop_motors for each control word. A start word clears the
// travelled angle, ramp, last error and action and yields no result.
// Configuration: write target, ramp step, gains and stop threshold through
// cfg_we / cfg_index / cfg_data while the block is idle.
// Pipeline: a word passes the input register, error stage, multiply stage
// and action/result register before its result is valid.
// Throughput: one word per cycle except while stalled (see below); the
// action recurrence closes through a single add and saturate in the last
// stage, the angle and ramp recurrences through the first stage.
// Reset: arst_n clears all valid flags and the running state, and loads the
// register defaults. Stall: while result is held, stages keep filling until
// the pipeline is full, then sample.ready drops; a start word can still
// drain past a held result.
module heading_pi_with_ramp import hpr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	hpr_in_if.sink              sample,
	hpr_out_if.source           result,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic [30:0]        target_q;
	logic [30:0]        step_q;
	logic signed [15:0] gain_now_q;
	logic signed [15:0] gain_prev_q;
	logic [30:0]        thr_q;

	err_word_t   err_s2;
	logic        v_s2;
	logic        err_ready;
	delta_word_t delta_s3;
	logic        v_s3;
	logic        delta_ready;

	// configuration registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= TargetRst;
			step_q      <= StepRst;
			gain_now_q  <= GainNowRst;
			gain_prev_q <= GainPrevRst;
			thr_q       <= ThresholdRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET:    target_q    <= cfg_data;
				CFG_STEP:      step_q      <= cfg_data;
				CFG_GAIN_NOW:  gain_now_q  <= $signed(cfg_data[15:0]);
				CFG_GAIN_PREV: gain_prev_q <= $signed(cfg_data[15:0]);
				CFG_THRESHOLD: thr_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: travelled angle, ramp setpoint, error
	hpr_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.target    (target_q),
		.step      (step_q),
		.err_s2    (err_s2),
		.v_s2      (v_s2),
		.err_ready (err_ready)
	);

	// stage 2: gain products and rounding
	hpr_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.err_s2      (err_s2),
		.v_s2        (v_s2),
		.err_ready   (err_ready),
		.gain_now    (gain_now_q),
		.gain_prev   (gain_prev_q),
		.delta_s3    (delta_s3),
		.v_s3        (v_s3),
		.delta_ready (delta_ready)
	);

	// stage 3: accumulate action, threshold, result register
	hpr_act u_act (
		.clk         (clk),
		.arst_n      (arst_n),
		.delta_s3    (delta_s3),
		.v_s3        (v_s3),
		.delta_ready (delta_ready),
		.threshold   (thr_q),
		.result      (result)
	);

`ifndef SYNTHESIS
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.stop_motors |-> result.drive == 31'd0)
		else $error("stop result with nonzero drive");

	a_drive_above: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.stop_motors |-> result.drive >= thr_q)
		else $error("drive below stop threshold without stop");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> result.valid && !result.ready)
		else $error("input blocked while output side not stalled");
`endif

endmodule

/* sv/hpr_track.sv */
module hpr_track import hpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	hpr_in_if.sink      sample,
	input  logic [30:0] target,
	input  logic [30:0] step,
	output err_word_t   err_s2,
	output logic        v_s2,
	input  logic        err_ready
);

	logic               v_s1;
	op_t                op_s1;
	logic signed [31:0] inc_s1;

	logic signed [31:0] trav_q;
	logic [30:0]        ramp_q;
	logic signed [31:0] prev_q;

	logic signed [32:0] trav_sum;
	logic signed [31:0] trav_new;
	logic [31:0]        ramp_sum;
	logic               fits;
	logic [30:0]        setpoint;
	logic signed [33:0] err_wide;
	logic signed [31:0] err;
	logic               fire;

	assign sample.ready = !v_s1 || err_ready;
	assign fire         = v_s1 && err_ready;

	always_comb begin
		trav_sum = 33'(trav_q) + 33'(inc_s1);
		trav_new = sat32(35'(trav_sum));
		ramp_sum = {1'b0, ramp_q} + {1'b0, step};
		fits     = ramp_sum <= {1'b0, target};
		setpoint = fits ? ramp_q : target;
		err_wide = $signed({3'b000, setpoint}) - 34'(trav_new);
		err      = sat32(35'(err_wide));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (sample.ready) v_s1 <= sample.valid;
			if (err_ready) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			op_s1  <= op_t'(sample.operation);
			inc_s1 <= sample.angle_increment;
		end
	end

	// running state advances once per item, in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trav_q <= '0;
			ramp_q <= '0;
			prev_q <= '0;
		end else if (fire) begin
			if (op_s1 == OP_START) begin
				trav_q <= '0;
				ramp_q <= '0;
				prev_q <= '0;
			end else begin
				trav_q <= trav_new;
				if (fits) ramp_q <= ramp_sum[30:0];
				prev_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			err_s2.op       <= op_s1;
			err_s2.err      <= (op_s1 == OP_START) ? 32'sd0 : err;
			err_s2.prev_err <= (op_s1 == OP_START) ? 32'sd0 : prev_q;
		end
	end

endmodule

/* sv/hpr_mac.sv */
module hpr_mac import hpr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  err_word_t          err_s2,
	input  logic               v_s2,
	output logic               err_ready,
	input  logic signed [15:0] gain_now,
	input  logic signed [15:0] gain_prev,
	output delta_word_t        delta_s3,
	output logic               v_s3,
	input  logic               delta_ready
);

	logic signed [47:0] p_now;
	logic signed [47:0] p_prev;
	logic signed [48:0] acc;

	assign err_ready = !v_s3 || delta_ready;

	// two Q17.31 products, round half up to Q18.16
	always_comb begin
		p_now  = gain_now * err_s2.err;
		p_prev = gain_prev * err_s2.prev_err;
		acc    = 49'(p_now) + 49'(p_prev) + 49'sd16384;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (err_ready) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (err_ready && v_s2) begin
			delta_s3.op    <= err_s2.op;
			delta_s3.delta <= $signed(acc[48:15]);
		end
	end

endmodule

/* sv/hpr_act.sv */
module hpr_act import hpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  delta_word_t delta_s3,
	input  logic        v_s3,
	output logic        delta_ready,
	input  logic [30:0] threshold,
	hpr_out_if.source   result
);

	logic signed [31:0] action_q;
	logic signed [31:0] action_new;
	logic               stop;
	logic               fire;
	logic               res_valid_q;
	logic [30:0]        drive_q;
	logic               stop_q;

	// a start word never needs the result register
	assign delta_ready = (delta_s3.op == OP_START) || !res_valid_q || result.ready;
	assign fire        = v_s3 && delta_ready;

	always_comb begin
		action_new = sat32(35'(action_q) + 35'(delta_s3.delta));
		stop       = 33'(action_new) < $signed({2'b00, threshold});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (result.ready) res_valid_q <= 1'b0;
			if (fire) begin
				if (delta_s3.op == OP_START) begin
					action_q <= '0;
				end else begin
					action_q    <= action_new;
					res_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && delta_s3.op == OP_SAMPLE) begin
			drive_q <= stop ? 31'd0 : action_new[30:0];
			stop_q  <= stop;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.drive       = drive_q;
	assign result.stop_motors = stop_q;

endmodule
